>>> rtl/wmm_pkg.sv
// ----------------------------------------------------------------------------
// Window min/max filter package
// Shared constants, payload types and the reduction helpers for the
// grayscale erosion/dilation filter.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_KERNEL  = 7;
    localparam int LINES       = MAX_KERNEL - 1;

    localparam int PIX_W       = 8;
    localparam int KSIZE_W     = 3;
    localparam int CFG_W       = 11;
    localparam int COORD_W     = 10;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
    localparam int LB_W        = PIX_W * LINES;

    localparam logic MODE_MAX  = 1'b0;
    localparam logic MODE_MIN  = 1'b1;

    typedef enum logic [1:0] {
        CFG_FILTER_MODE = 2'd0,
        CFG_KERNEL_SIZE = 2'd1,
        CFG_IMAGE_WIDTH = 2'd2
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t pixel_value;
        logic   frame_start;
    } pixel_in_t;

    typedef struct packed {
        pixel_t             result_value;
        logic [COORD_W-1:0] result_col;
        logic [COORD_W-1:0] result_row;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [LB_W-1:0]   data;
    } lb_wr_t;

    function automatic pixel_t wmm_pick(input pixel_t a, input pixel_t b, input logic mode);
        pixel_t r;
        if (mode == MODE_MIN)
        begin
            r = (b < a) ? b : a;
        end
        else
        begin
            r = (b > a) ? b : a;
        end
        return r;
    endfunction

    // Reduces the first k entries; the others are replaced by the neutral value.
    function automatic pixel_t wmm_reduce(input pixel_t vals [MAX_KERNEL],
                                          input logic [KSIZE_W-1:0] k,
                                          input logic mode);
        pixel_t acc;
        acc = (mode == MODE_MIN) ? '1 : '0;
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            if (i < int'(k))
            begin
                acc = wmm_pick(acc, vals[i], mode);
            end
        end
        return acc;
    endfunction

endpackage

>>> rtl/wmm_line_buffer.sv
// ----------------------------------------------------------------------------
// Window min/max line buffer
// One memory word per column holds that column's pixels from the previous
// rows. Registered read with bypass of a same-cycle write to the same column.
// ----------------------------------------------------------------------------
module wmm_line_buffer (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [wmm_pkg::ADDR_W-1:0]   rd_addr,
    output logic [wmm_pkg::LB_W-1:0]     rd_data,
    input  wmm_pkg::lb_wr_t              wr
);
    import wmm_pkg::*;

    logic [LB_W-1:0] mem [MAX_WIDTH];
    logic [LB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/window_min_max_filter.sv
// ----------------------------------------------------------------------------
// Window min/max filter
// Streaming grayscale erosion/dilation over the valid region of a frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel, with frame_start marking the
// first pixel of a frame. Once a full kernel_size by kernel_size window lies
// inside the image, a transfer on the out channel carries its maximum
// (filter_mode 0) or minimum (filter_mode 1), tagged with the window's
// top-left column and row. Border positions and even kernel sizes give none.
// The block takes one pixel per cycle while in_ready is high. After the transfer
// of the pixel that completes its window, the result passes through the line
// buffer read, the window shift, the column reductions and the reduction
// across columns into the output register, each registered in turn.
// Each stage holds its item only when the stage behind it is full, so a stall
// of the receiver fills the pipeline before in_ready drops.
// Reset clears the pixel counters and empties the pipeline; the next pixel
// counts as the start of a frame. Line buffer and window contents are not
// cleared. Configuration writes through cfg_we take effect at once and belong
// between frames, while no pixel is in flight.
// ----------------------------------------------------------------------------
module window_min_max_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  wmm_pkg::pixel_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output wmm_pkg::result_t            out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [wmm_pkg::CFG_W-1:0]   cfg_data
);
    import wmm_pkg::*;

    logic                 filter_mode_reg;
    logic [KSIZE_W-1:0]   kernel_size_reg;
    logic [CFG_W-1:0]     image_width_reg;

    logic [CNT_W-1:0]     col_count_reg, col_count_next;
    logic [ROW_W-1:0]     row_count_reg, row_count_next;

    logic [CNT_W-1:0]     eff_w;
    logic [CNT_W-1:0]     col_a, col_b, ocol_full;
    logic [ROW_W-1:0]     row_a, row_b, orow_full;
    logic                 wrap, ignore, accept, enter, emit;

    logic                 en2, en3, en_out;

    logic                 s1_valid_reg, s1_emit_reg;
    pixel_t               s1_pix_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [COORD_W-1:0]   s1_ocol_reg, s1_orow_reg;
    logic [LB_W-1:0]      rd_data;
    lb_wr_t               lb_wr;
    pixel_t               column [MAX_KERNEL];

    pixel_t               window_reg [MAX_KERNEL][MAX_KERNEL];
    logic                 s2_valid_reg;
    logic [COORD_W-1:0]   s2_ocol_reg, s2_orow_reg;
    pixel_t               colres_next [MAX_KERNEL];

    logic                 s3_valid_reg;
    pixel_t               colres_reg [MAX_KERNEL];
    logic [COORD_W-1:0]   s3_ocol_reg, s3_orow_reg;

    logic                 out_valid_reg;
    result_t              out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= MODE_MAX;
            kernel_size_reg <= KSIZE_W'(3);
            image_width_reg <= CFG_W'(640);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FILTER_MODE: filter_mode_reg <= cfg_data[0];
                CFG_KERNEL_SIZE: kernel_size_reg <= cfg_data[KSIZE_W-1:0];
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position of the incoming pixel and its result tag.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            eff_w = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CNT_W'(image_width_reg);
        end

        col_a = in_data.frame_start ? '0 : col_count_reg;
        row_a = in_data.frame_start ? '0 : row_count_reg;
        wrap  = (col_a >= eff_w);
        col_b = wrap ? '0 : col_a;
        if (wrap && (int'(row_a) < MAX_HEIGHT))
        begin
            row_b = row_a + ROW_W'(1);
        end
        else
        begin
            row_b = row_a;
        end
        ignore = (int'(row_b) >= MAX_HEIGHT);

        emit = kernel_size_reg[0] && (int'(kernel_size_reg) <= MAX_KERNEL)
               && (row_b >= ROW_W'(kernel_size_reg - KSIZE_W'(1)))
               && (col_b >= CNT_W'(kernel_size_reg - KSIZE_W'(1)));
        ocol_full = col_b + CNT_W'(1) - CNT_W'(kernel_size_reg);
        orow_full = row_b + ROW_W'(1) - ROW_W'(kernel_size_reg);

        accept = in_valid && in_ready;
        enter  = accept && !ignore;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            col_count_next = ignore ? col_b : (col_b + CNT_W'(1));
            row_count_next = row_b;
        end
    end

    // Stage enables: a stage moves when the one after it is empty or moving.
    assign en_out   = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en_out;
    assign en2      = !s2_valid_reg || en3;
    assign in_ready = !s1_valid_reg || en2;

    wmm_line_buffer u_line_buffer (
        .clk     (clk),
        .rd_en   (enter),
        .rd_addr (col_b[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr      (lb_wr)
    );

    always_comb
    begin
        column[0] = s1_pix_reg;
        for (int i = 1; i < MAX_KERNEL; i++)
        begin
            column[i] = rd_data[(i-1)*PIX_W +: PIX_W];
        end
        lb_wr.en   = s1_valid_reg && en2;
        lb_wr.addr = s1_addr_reg;
        lb_wr.data = {rd_data[LB_W-PIX_W-1:0], s1_pix_reg};
    end

    always_comb
    begin
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            colres_next[c] = wmm_reduce(window_reg[c], kernel_size_reg, filter_mode_reg);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (in_ready)
            begin
                s1_valid_reg <= enter;
                s1_emit_reg  <= enter && emit;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_pix_reg  <= in_data.pixel_value;
            s1_addr_reg <= col_b[ADDR_W-1:0];
            s1_ocol_reg <= ocol_full[COORD_W-1:0];
            s1_orow_reg <= orow_full[COORD_W-1:0];
        end
        if (s1_valid_reg && en2)
        begin
            for (int c = MAX_KERNEL - 1; c > 0; c--)
            begin
                window_reg[c] <= window_reg[c-1];
            end
            window_reg[0] <= column;
            s2_ocol_reg   <= s1_ocol_reg;
            s2_orow_reg   <= s1_orow_reg;
        end
        if (en3 && s2_valid_reg)
        begin
            colres_reg  <= colres_next;
            s3_ocol_reg <= s2_ocol_reg;
            s3_orow_reg <= s2_orow_reg;
        end
        if (en_out && s3_valid_reg)
        begin
            out_data_reg.result_value <= wmm_reduce(colres_reg, kernel_size_reg,
                                                    filter_mode_reg);
            out_data_reg.result_col   <= s3_ocol_reg;
            out_data_reg.result_row   <= s3_orow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pixel inside the image moves the column count on by one.
    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.frame_start && !wrap && !ignore)
        |=> (col_count_reg == $past(col_count_reg) + CNT_W'(1)))
        else $error("column count did not advance after a pixel transfer");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_count_reg) <= MAX_WIDTH)
        else $error("column count beyond the maximum width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_count_reg) <= MAX_HEIGHT)
        else $error("row count beyond the maximum height");

    // A stalled output register keeps the result waiting behind it.
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s3_valid_reg) |=> s3_valid_reg)
        else $error("pending result lost while the output was stalled");

endmodule

>>> tb/window_min_max_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window min/max filter testbench
// Streams raster frames through the filter under random stalls on both
// channels and checks every result transfer against a cycle-free predictor
// of the line buffers, the sliding window and the pixel counters.
// ----------------------------------------------------------------------------
module window_min_max_filter_tb;

    import wmm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pixel_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    result_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    pixel_in_t pending_pixels[$];
    result_t expected_results[$];

    logic in_taken = 1'b0;
    logic [15:0] cycle_count = '0;
    int unsigned stall_cycles = 0;
    int unsigned queued_pixels = 0;
    int unsigned pixels_in = 0;
    int unsigned results_out = 0;
    int unsigned reg_writes = 0;
    int unsigned fail_count = 0;

    // Filter state as seen by the predictor.
    logic filter_mode_q = MODE_MAX;
    logic [KSIZE_W-1:0] kernel_q = 3'd3;
    logic [CFG_W-1:0] width_q = 11'd640;
    pixel_t prev_rows [LINES][MAX_WIDTH];
    pixel_t window_px [MAX_KERNEL][MAX_KERNEL];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    wire quiet = (cycle_count[10:8] == 3'b111);

    window_min_max_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic filter_pixel(input pixel_in_t px);
        int unsigned w;
        int unsigned k;
        pixel_t acc;
        pixel_t v;
        result_t res;
        w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
        k = kernel_q;
        if (px.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            if (row_pos < MAX_HEIGHT)
            begin
                row_pos++;
            end
        end
        if (row_pos < MAX_HEIGHT)
        begin
            for (int c = MAX_KERNEL - 1; c > 0; c--)
            begin
                for (int i = 0; i < MAX_KERNEL; i++)
                begin
                    window_px[c][i] = window_px[c-1][i];
                end
            end
            window_px[0][0] = px.pixel_value;
            for (int i = 1; i < MAX_KERNEL; i++)
            begin
                window_px[0][i] = prev_rows[i-1][col_pos];
            end
            for (int i = LINES - 1; i > 0; i--)
            begin
                prev_rows[i][col_pos] = prev_rows[i-1][col_pos];
            end
            prev_rows[0][col_pos] = px.pixel_value;
            if ((k % 2) == 1 && k <= MAX_KERNEL && row_pos + 1 >= k && col_pos + 1 >= k)
            begin
                acc = window_px[0][0];
                for (int c = 0; c < k; c++)
                begin
                    for (int i = 0; i < k; i++)
                    begin
                        v = window_px[c][i];
                        if (filter_mode_q == MODE_MIN)
                        begin
                            acc = (v < acc) ? v : acc;
                        end
                        else
                        begin
                            acc = (v > acc) ? v : acc;
                        end
                    end
                end
                res.result_value = acc;
                res.result_col = COORD_W'(col_pos + 1 - k);
                res.result_row = COORD_W'(row_pos + 1 - k);
                expected_results.push_back(res);
            end
            col_pos++;
        end
    endtask

    // Driver: one transfer candidate per falling edge, once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_pixels.size() != 0 && (quiet || $urandom_range(0, 99) >= 33))
                begin
                    in_data <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 33);
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1'b1;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                pixels_in++;
                filter_pixel(in_data);
            end
            if (out_valid && out_ready)
            begin
                results_out++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: value %0d col %0d row %0d",
                           out_data.result_value, out_data.result_col, out_data.result_row);
                    fail_count++;
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (out_data.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, out_data.result_value);
                        fail_count++;
                    end
                    if (out_data.result_col !== want.result_col)
                    begin
                        $error("result_col: expected %0d, got %0d",
                               want.result_col, out_data.result_col);
                        fail_count++;
                    end
                    if (out_data.result_row !== want.result_row)
                    begin
                        $error("result_row: expected %0d, got %0d",
                               want.result_row, out_data.result_row);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
        begin
            stall_cycles <= stall_cycles + 1;
        end
        else
        begin
            stall_cycles <= 0;
        end
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
            $display("window_min_max_filter: mismatch");
            $finish;
        end
    end

    task automatic push_pixel(input pixel_t value, input logic fs);
        pixel_in_t item;
        item.pixel_value = value;
        item.frame_start = fs;
        pending_pixels.push_back(item);
        queued_pixels++;
    endtask

    // Waits until the block is idle, including pixels that give no result.
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_FILTER_MODE: filter_mode_q = value[0];
            CFG_KERNEL_SIZE: kernel_q = value[KSIZE_W-1:0];
            CFG_IMAGE_WIDTH: width_q = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned n_px, input logic first_start,
                              input int unsigned start_pct);
        int unsigned pick;
        pixel_t value;
        for (int unsigned i = 0; i < n_px; i++)
        begin
            pick = $urandom_range(0, 19);
            value = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hFF : 8'($urandom));
            push_pixel(value, (i == 0) ? first_start : ($urandom_range(0, 99) < start_pct));
        end
        drain();
    endtask

    initial
    begin
        pixel_t grid [12];
        int unsigned kind;
        int unsigned ksize;
        int unsigned width;
        int unsigned height;
        int unsigned partial;
        grid = '{8'd0, 8'd255, 8'd7, 8'd9, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd200, 8'd8};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, no frame mark: the reset state opens a frame.
        push_pixel(8'd10, 1'b0);
        push_pixel(8'd20, 1'b0);
        push_pixel(8'd30, 1'b0);
        drain();

        cfg_write(CFG_FILTER_MODE, CFG_W'(MODE_MAX));
        cfg_write(CFG_KERNEL_SIZE, 11'd3);
        cfg_write(CFG_IMAGE_WIDTH, 11'd4);
        for (int i = 0; i < 12; i++)
        begin
            push_pixel(grid[i], i == 0);
        end
        drain();

        // A width of zero behaves as one, so each pixel is its own window.
        cfg_write(CFG_FILTER_MODE, CFG_W'(MODE_MIN));
        cfg_write(CFG_KERNEL_SIZE, 11'd1);
        cfg_write(CFG_IMAGE_WIDTH, 11'd0);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd128, 1'b0);
        drain();

        cfg_write(CFG_FILTER_MODE, CFG_W'(MODE_MAX));
        cfg_write(CFG_KERNEL_SIZE, 11'd2);
        cfg_write(CFG_IMAGE_WIDTH, 11'd3);
        for (int i = 0; i < 6; i++)
        begin
            push_pixel(grid[i], i == 0);
        end
        drain();

        while (queued_pixels < 940)
        begin
            kind = $urandom_range(0, 9);
            ksize = (kind == 7) ? 2 * $urandom_range(0, 3) : 2 * $urandom_range(0, 3) + 1;
            width = $urandom_range(1, 12);
            height = $urandom_range(1, ksize + 3);
            cfg_write(CFG_FILTER_MODE, CFG_W'($urandom_range(0, 1)));
            cfg_write(CFG_KERNEL_SIZE, CFG_W'(ksize));
            if (kind == 9)
            begin
                // The width drops while a row is under way.
                width = $urandom_range(3, 12);
                partial = $urandom_range(1, width - 1);
                cfg_write(CFG_IMAGE_WIDTH, CFG_W'(width));
                send_frame(width * $urandom_range(1, ksize) + partial, 1'b1, 0);
                width = $urandom_range(1, width - 1);
                cfg_write(CFG_IMAGE_WIDTH, CFG_W'(width));
                send_frame(width * $urandom_range(1, ksize + 2), 1'b0, 0);
            end
            else
            begin
                cfg_write(CFG_IMAGE_WIDTH, CFG_W'(width));
                send_frame(width * height, 1'b1, (kind == 8) ? 5 : 0);
            end
        end

        $display("Covered %0d pixel transfers and %0d result transfers across %0d register writes.",
                 pixels_in, results_out, reg_writes);
        if (fail_count == 0)
        begin
            $display("window_min_max_filter: match");
        end
        else
        begin
            $display("window_min_max_filter: mismatch");
        end
        $finish;
    end

endmodule
